FILE: rtl/q4dot_pkg.sv
// ----------------------------------------------------------------------------
// q4dot_pkg
// Shared widths, defaults and controller/datapath interface types for the
// Q4 x int8 group dot product block.
// ----------------------------------------------------------------------------
package q4dot_pkg;

  localparam int unsigned GroupSizeDef = 128;

  localparam int unsigned WbW     = 8;
  localparam int unsigned ActW    = 8;
  localparam int unsigned WsW     = 16;
  localparam int unsigned AsW     = 24;
  localparam int unsigned InDataW = WbW + 2 * ActW + WsW + AsW;

  localparam int unsigned AccW     = 64;
  localparam int unsigned RowIdxW  = 12;
  localparam int unsigned OutDataW = ((AccW + RowIdxW + 7) / 8) * 8;

  // Largest magnitude of one item's two products: (-8) * (-128) twice.
  localparam int unsigned ItemMaxMag = 2048;

  typedef struct packed {
    logic acc_item;  // item accepted: add products, step group counter
    logic mul_a;     // group sum times weight scale
    logic mul_b;     // times activation scale
    logic add_term;  // saturating add into the row accumulator
    logic load_out;  // move row result to the output register, start new row
  } cmd_t;

  typedef struct packed {
    logic closing;   // the item on the input closes its group
    logic row_last;  // the group just closed ends the row
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

FILE: rtl/q4dot_ctrl.sv
// ----------------------------------------------------------------------------
// q4dot_ctrl
// Sequencer: accumulate items, then scale and add each closed group, then
// hand the row result to the output register.
// ----------------------------------------------------------------------------
module q4dot_ctrl
  import q4dot_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_ACCUM = 5'b00001,
    ST_MUL_A = 5'b00010,
    ST_MUL_B = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready_o = (state_q == ST_ACCUM);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACCUM: begin
        if (s_axis_tvalid_i) begin
          cmd_o.acc_item = 1'b1;
          if (sts_i.closing) begin
            state_d = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_term = 1'b1;
        state_d        = sts_i.row_last ? ST_EMIT : ST_ACCUM;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  a_close_starts_scaling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCUM && s_axis_tvalid_i && sts_i.closing) |=> (state_q == ST_MUL_A))
    else $error("closing item did not start group scaling");

  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && sts_i.out_free) |=> (state_q == ST_ACCUM))
    else $error("emit did not return to accumulation");

  a_scale_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_a |=> cmd_o.mul_b ##1 cmd_o.add_term)
    else $error("group scaling sequence broken");

endmodule

FILE: rtl/q4dot_dp.sv
// ----------------------------------------------------------------------------
// q4dot_dp
// Datapath: nibble products, exact group sum, two-step scale multiply,
// saturating 64-bit row accumulator and the output register.
// ----------------------------------------------------------------------------
module q4dot_dp
  import q4dot_pkg::*;
#(
  parameter int unsigned GROUP_ELEMS = GroupSizeDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [InDataW-1:0]    s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OutDataW-1:0]   m_axis_tdata_o,
  output logic                  m_axis_tuser_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned Items = GROUP_ELEMS / 2;
  localparam int unsigned CntW  = $clog2(Items);
  localparam int unsigned GsW   = $clog2(Items * ItemMaxMag) + 2;
  localparam int unsigned P1W   = GsW + WsW;
  localparam int unsigned P2W   = P1W + AsW;
  localparam logic [CntW-1:0] CntLast = CntW'(Items - 1);

  // unpack the input item
  logic [WbW-1:0]         wb;
  logic signed [ActW-1:0] act_even, act_odd;
  logic signed [WsW-1:0]  ws_in;
  logic signed [AsW-1:0]  as_in;
  assign wb       = s_axis_tdata_i[WbW-1:0];
  assign act_even = s_axis_tdata_i[WbW +: ActW];
  assign act_odd  = s_axis_tdata_i[WbW + ActW +: ActW];
  assign ws_in    = s_axis_tdata_i[WbW + 2 * ActW +: WsW];
  assign as_in    = s_axis_tdata_i[WbW + 2 * ActW + WsW +: AsW];

  // nibble minus 8 is the nibble with its top bit flipped, read as signed
  logic signed [3:0]         w_lo, w_hi;
  logic signed [ActW+3:0]    prod_lo, prod_hi;
  logic signed [ActW+4:0]    item_sum;
  assign w_lo     = {~wb[3], wb[2:0]};
  assign w_hi     = {~wb[7], wb[6:4]};
  assign prod_lo  = (ActW + 4)'(w_lo) * (ActW + 4)'(act_even);
  assign prod_hi  = (ActW + 4)'(w_hi) * (ActW + 4)'(act_odd);
  assign item_sum = (ActW + 5)'(prod_lo) + (ActW + 5)'(prod_hi);

  logic [CntW-1:0]        cnt_q;
  logic signed [GsW-1:0]  gs_q;
  logic signed [WsW-1:0]  ws_q;
  logic signed [AsW-1:0]  as_q;
  logic                   last_q;
  logic signed [P1W-1:0]  p1_q, p1_d;
  logic signed [P2W-1:0]  p2_q, p2_d;
  logic [AccW-1:0]        acc_q;
  logic                   sat_q;
  logic [RowIdxW-1:0]     row_cnt_q;
  logic                   out_valid_q;
  logic [AccW-1:0]        out_value_q;
  logic [RowIdxW-1:0]     out_index_q;
  logic                   out_ovf_q;

  logic signed [GsW-1:0]  item_ext;
  assign item_ext = {{(GsW - ActW - 5){item_sum[ActW+4]}}, item_sum};

  assign p1_d = P1W'(gs_q) * P1W'(ws_q);
  assign p2_d = P2W'(p1_q) * P2W'(as_q);

  // saturating add of the scaled group term
  logic [AccW-1:0] term, acc_sum;
  logic            acc_ovf;
  assign term    = {{(AccW - P2W){p2_q[P2W-1]}}, p2_q};
  assign acc_sum = acc_q + term;
  assign acc_ovf = (acc_q[AccW-1] == term[AccW-1]) && (acc_sum[AccW-1] != acc_q[AccW-1]);

  assign sts_o.closing  = s_axis_tlast_i || (cnt_q == CntLast);
  assign sts_o.row_last = last_q;
  assign sts_o.out_free = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - AccW - RowIdxW){1'b0}}, out_index_q, out_value_q};
  assign m_axis_tuser_o  = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      gs_q        <= '0;
      ws_q        <= '0;
      as_q        <= '0;
      last_q      <= 1'b0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_item) begin
        gs_q   <= gs_q + item_ext;
        last_q <= s_axis_tlast_i;
        if (cnt_q == '0) begin
          ws_q <= ws_in;
          as_q <= as_in;
        end
        if (sts_o.closing) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.mul_a) begin
        gs_q <= '0;
      end
      if (cmd_i.add_term) begin
        if (acc_ovf) begin
          acc_q <= term[AccW-1] ? {1'b1, {(AccW - 1){1'b0}}} : {1'b0, {(AccW - 1){1'b1}}};
          sat_q <= 1'b1;
        end else begin
          acc_q <= acc_sum;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        acc_q       <= '0;
        sat_q       <= 1'b0;
        row_cnt_q   <= row_cnt_q + RowIdxW'(1);
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      p1_q <= p1_d;
    end
    if (cmd_i.mul_b) begin
      p2_q <= p2_d;
    end
    if (cmd_i.load_out) begin
      out_value_q <= acc_q;
      out_index_q <= row_cnt_q;
      out_ovf_q   <= sat_q;
    end
  end

  a_load_clears_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> (m_axis_tvalid_o && acc_q == '0 && !sat_q))
    else $error("row state not cleared after result load");

  a_group_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_a |=> (gs_q == '0 && cnt_q == '0))
    else $error("group state not cleared after group close");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !cmd_i.load_out)
    else $error("pending result overwritten");

endmodule

FILE: rtl/q4_int8_group_dot_product.sv
// ----------------------------------------------------------------------------
// q4_int8_group_dot_product
// Q4 x int8 group-quantized dot product of one matrix row per result.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one item per packed weight byte with its two int8
// activations; the group scales ride along and are taken on the first item
// of each group of GROUP_ELEMS/2 items. tlast marks the last item of a row.
// Output stream (m_axis): one item per row with the saturated row value
// (31 fraction bits) and a wrapping 12-bit row number; tuser flags overflow.
//
// Throughput: one item per cycle inside a group. Each closed group then
// holds the input through the two-step scale multiply and the saturating
// accumulator add (ST_MUL_A, ST_MUL_B, ST_ADD); a row's end then passes
// ST_EMIT, which loads the output register and so raises m_axis_tvalid
// once the register is free.
//
// Reset clears the row and group accumulators and the row number, and
// empties the output register. When the receiver stalls, a finished row
// waits in the output register while the next row accumulates; the input
// stalls only once the following row result is ready and the register is
// still full.
// ----------------------------------------------------------------------------
module q4_int8_group_dot_product
  import q4dot_pkg::*;
#(
  parameter int unsigned GROUP_ELEMS = GroupSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // weight_byte, act_even, act_odd, weight_scale, act_scale (low bit up)
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tlast_i,  // row_last
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // row_value, row_index, zero pad (low bit up)
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o   // overflow
);

  cmd_t cmd;
  sts_t sts;

  q4dot_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  q4dot_dp #(
    .GROUP_ELEMS (GROUP_ELEMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for q4_int8_group_dot_product. Items go through a
// bursty sender into the block, while a scoreboard model tracks group sums,
// group scales and the saturating row accumulator. Each row result is checked
// against the model's prediction as the stalling receiver takes it. Tests
// cover directed extremes, full and partial groups, back-pressure and random
// rows.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import q4dot_pkg::*;

  localparam int GroupItems  = GroupSizeDef / 2;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 3000;
  localparam int RandomItems = 140;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW - 1){1'b0}}};

  typedef struct {
    logic        [WbW-1:0]  weight_byte;
    logic signed [ActW-1:0] act_even;
    logic signed [ActW-1:0] act_odd;
    logic signed [WsW-1:0]  weight_scale;
    logic signed [AsW-1:0]  act_scale;
    logic                   row_last;
  } q4_item_t;

  typedef struct {
    logic signed [AccW-1:0]    row_value;
    logic        [RowIdxW-1:0] row_index;
    logic                      overflow;
  } row_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  // Row model state
  longint                   grp_sum   = 0;
  int                       grp_pos   = 0;
  logic signed [WsW-1:0]    grp_ws    = '0;
  logic signed [AsW-1:0]    grp_as    = '0;
  logic signed [AccW-1:0]   row_total = '0;
  logic                     row_sat   = 1'b0;
  logic        [RowIdxW-1:0] row_num  = '0;
  row_result_t              pending_rows[$];

  int fail_count  = 0;
  int idle_cycles = 0;

  // Sender and receiver pacing
  bit          tx_gaps_on = 1'b1;
  int          burst_left = 0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int          phase_left = 0;
  int          rx_tick    = 0;
  rx_pattern_e rx_pattern = RX_ALWAYS;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  q4_int8_group_dot_product uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  function automatic q4_item_t make_item(input logic [WbW-1:0] wb,
                                         input int ae,
                                         input int ao,
                                         input int ws,
                                         input int a_sc,
                                         input logic last);
    q4_item_t it;
    it.weight_byte  = wb;
    it.act_even     = ActW'(ae);
    it.act_odd      = ActW'(ao);
    it.weight_scale = WsW'(ws);
    it.act_scale    = AsW'(a_sc);
    it.row_last     = last;
    return it;
  endfunction

  // Lean toward the corners of each field now and then.
  function automatic q4_item_t random_item(input logic last);
    q4_item_t it;
    case ($urandom_range(0, 7))
      0:       it.weight_byte = 8'h00;
      1:       it.weight_byte = 8'hFF;
      default: it.weight_byte = WbW'($urandom);
    endcase
    it.act_even = ($urandom_range(0, 3) == 0) ?
                  ($urandom_range(0, 1) ? 8'sh80 : 8'sh7F) : ActW'($urandom);
    it.act_odd  = ($urandom_range(0, 3) == 0) ?
                  ($urandom_range(0, 1) ? 8'sh80 : 8'sh7F) : ActW'($urandom);
    it.weight_scale = ($urandom_range(0, 4) == 0) ?
                      ($urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF) : WsW'($urandom);
    it.act_scale    = ($urandom_range(0, 4) == 0) ?
                      ($urandom_range(0, 1) ? 24'sh800000 : 24'sh7FFFFF) : AsW'($urandom);
    it.row_last = last;
    return it;
  endfunction

  // Fold one accepted item into the row model; queue the row result on last.
  task automatic accumulate_item(input q4_item_t it);
    longint                 w_lo;
    longint                 w_hi;
    longint                 term;
    logic signed [AccW-1:0] sum;
    row_result_t            res;
    w_lo = longint'(it.weight_byte[3:0]) - 8;
    w_hi = longint'(it.weight_byte[7:4]) - 8;
    if (grp_pos == 0) begin
      grp_ws = it.weight_scale;
      grp_as = it.act_scale;
    end
    grp_sum += w_lo * longint'(it.act_even) + w_hi * longint'(it.act_odd);
    if (it.row_last || grp_pos + 1 >= GroupItems) begin
      term = grp_sum * longint'(grp_ws) * longint'(grp_as);
      sum  = row_total + term;
      if ((row_total[AccW-1] == term[63]) && (sum[AccW-1] != row_total[AccW-1])) begin
        row_total = term[63] ? AccMin : AccMax;
        row_sat   = 1'b1;
      end else begin
        row_total = sum;
      end
      grp_sum = 0;
      grp_pos = 0;
    end else begin
      grp_pos++;
    end
    if (it.row_last) begin
      res.row_value = row_total;
      res.row_index = row_num;
      res.overflow  = row_sat;
      pending_rows.push_back(res);
      row_total = '0;
      row_sat   = 1'b0;
      row_num++;
    end
  endtask

  task automatic send_item(input q4_item_t it);
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {it.act_scale, it.weight_scale, it.act_odd, it.act_even,
                        it.weight_byte};
    s_axis_tlast_i  <= it.row_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_item(it);
  endtask

  task automatic wait_rows_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rows.size() != 0);
  endtask

  // One full group of the largest product magnitude; group sum is +131072.
  task automatic send_max_group(input int ws,
                                input int a_sc,
                                input logic ends_row);
    for (int k = 0; k < GroupItems; k++) begin
      send_item(make_item(8'h00, -128, -128, ws, a_sc, ends_row && (k == GroupItems - 1)));
    end
  endtask

  task automatic test_directed_extremes();
    send_item(make_item(8'h88, 0, 0, 0, 0, 1'b1));
    send_item(make_item(8'h00, -128, -128, -32768, -8388608, 1'b1));
    send_item(make_item(8'hFF, 127, 127, 32767, 8388607, 1'b1));
    send_item(make_item(8'h0F, -128, 127, 32767, -8388608, 1'b1));
    send_item(make_item(8'hF0, 127, -128, -32768, 8388607, 1'b1));
    send_item(make_item(8'h00, 127, -128, 1, 1, 1'b1));
    send_item(make_item(8'hFF, -128, -128, -1, -1, 1'b1));
    send_item(make_item(8'h00, -128, -128, 0, 8388607, 1'b1));
    // Scales on later items of a group must be ignored.
    send_item(make_item(8'h5A, 100, -3, 12345, -654321, 1'b0));
    send_item(make_item(8'hA5, -77, 55, 0, 0, 1'b0));
    send_item(make_item(8'h31, 5, -128, -32768, 8388607, 1'b1));
    wait_rows_drained();
  endtask

  task automatic test_full_groups();
    // Row that ends exactly on a group boundary.
    send_max_group(-32768, -8388608, 1'b1);
    // Full group followed by a short one with new scales.
    send_max_group(-32768, -8388608, 1'b0);
    send_item(make_item(8'hFF, 127, -128, 32767, 8388607, 1'b0));
    send_item(make_item(8'h00, -128, 127, 0, 0, 1'b1));
    // Three groups, the last one partial, with random content.
    for (int k = 0; k < 2 * GroupItems + 9; k++) begin
      send_item(random_item(k == 2 * GroupItems + 8));
    end
    wait_rows_drained();
  endtask

  task automatic test_backpressure();
    int len;
    tx_gaps_on = 1'b0;
    hold_req <= hold_req + 1;
    for (int r = 0; r < 16; r++) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) send_item(random_item(k == len - 1));
    end
    // Pause the sender until every row is out.
    wait_rows_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_rows();
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 7) ? $urandom_range(1, 16) :
             (pick < 9) ? $urandom_range(17, 64) : $urandom_range(65, 160);
      if (len > RandomItems - sent) len = RandomItems - sent;
      for (int k = 0; k < len; k++) begin
        send_item(random_item(k == len - 1));
        sent++;
      end
    end
    wait_rows_drained();
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_pattern = rx_pattern_e'($urandom_range(0, 3));
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      rx_tick++;
      case (rx_pattern)
        RX_ALWAYS:   m_axis_tready_i <= 1'b1;
        RX_COIN:     m_axis_tready_i <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_axis_tready_i <= (rx_tick % 4) != 0;
        default:     m_axis_tready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_rows
    row_result_t                want;
    logic signed [AccW-1:0]     got_value;
    logic        [RowIdxW-1:0]  got_index;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_value = m_axis_tdata_o[AccW-1:0];
      got_index = m_axis_tdata_o[AccW +: RowIdxW];
      if (pending_rows.size() == 0) begin
        $error("unexpected row result: row_value %0d, row_index %0d", got_value, got_index);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        if (got_value !== want.row_value) begin
          $error("row_value: expected %0d, actual %0d", want.row_value, got_value);
          fail_count++;
        end
        if (got_index !== want.row_index) begin
          $error("row_index: expected %0d, actual %0d", want.row_index, got_index);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_full_groups();
    test_backpressure();
    test_random_rows();
    wait_rows_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending_rows.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
